### hdl/sfss_pkg.sv
package sfss_pkg;

    // Raw sensor value and fixed-point arithmetic widths
    localparam int RAW_W    = 20;
    localparam int SCALE_W  = 28;
    localparam int DIGIT_W  = 7;
    localparam int SEG_W    = 8;
    localparam int BYTE_W   = 8;

    // Scaling: T = (200*raw - 50*2^20) / 2^20, H = 100*raw / 2^20
    localparam logic [SCALE_W-1:0] TEMP_GAIN     = SCALE_W'(200);
    localparam logic [SCALE_W-1:0] HUMID_GAIN    = SCALE_W'(100);
    localparam logic [SCALE_W-1:0] FRAC_ONE      = SCALE_W'(1048576);
    localparam logic [SCALE_W-1:0] TEMP_OFFSET_N = SCALE_W'(52428800);
    localparam logic [SCALE_W-1:0] TEN_ONE       = SCALE_W'(10485760);
    localparam logic [SCALE_W-1:0] TIMES_TEN     = SCALE_W'(10);
    localparam logic [DIGIT_W-1:0] DISPLAY_MAX   = DIGIT_W'(99);

    // Active-low segment codes
    localparam logic [SEG_W-1:0] SEG_MINUS    = 8'hFD;
    localparam logic [SEG_W-1:0] SEG_DOT_MASK = 8'hEF;
    localparam logic [SEG_W-1:0] SEG_BLANK    = 8'hFF;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [SEG_W-1:0]  t_seg;

    // Quotient by ten for values up to 127: x*205 >> 11
    function automatic logic [3:0] f_div10(input logic [DIGIT_W-1:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[14:11];
    endfunction

    // Remainder by ten for values up to 127
    function automatic logic [3:0] f_mod10(input logic [DIGIT_W-1:0] x);
        logic [DIGIT_W-1:0] r;
        r = x - DIGIT_W'(f_div10(x)) * DIGIT_W'(10);
        return r[3:0];
    endfunction

    // Digit to active-low segment code
    function automatic t_seg f_seg(input logic [3:0] d);
        t_seg s;
        case (d)
            4'd0:    s = 8'h12;
            4'd1:    s = 8'h9F;
            4'd2:    s = 8'h31;
            4'd3:    s = 8'h15;
            4'd4:    s = 8'h9C;
            4'd5:    s = 8'h54;
            4'd6:    s = 8'h50;
            4'd7:    s = 8'h1F;
            4'd8:    s = 8'h10;
            4'd9:    s = 8'h14;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

### hdl/sfss_frame_if.sv
interface sfss_frame_if;
    logic                valid;
    logic                ready;
    sfss_pkg::t_byte     frame_byte1;
    sfss_pkg::t_byte     frame_byte2;
    sfss_pkg::t_byte     frame_byte3;
    sfss_pkg::t_byte     frame_byte4;
    sfss_pkg::t_byte     frame_byte5;

    modport source (output valid, frame_byte1, frame_byte2, frame_byte3,
                    frame_byte4, frame_byte5, input ready);
    modport sink   (input valid, frame_byte1, frame_byte2, frame_byte3,
                    frame_byte4, frame_byte5, output ready);
endinterface

### hdl/sfss_seg_if.sv
interface sfss_seg_if;
    logic            valid;
    logic            ready;
    sfss_pkg::t_seg  temp_first_segments;
    sfss_pkg::t_seg  temp_second_segments;
    sfss_pkg::t_seg  humid_tens_segments;
    sfss_pkg::t_seg  humid_units_segments;

    modport source (output valid, temp_first_segments, temp_second_segments,
                    humid_tens_segments, humid_units_segments, input ready);
    modport sink   (input valid, temp_first_segments, temp_second_segments,
                    humid_tens_segments, humid_units_segments, output ready);
endinterface

### hdl/sensor_frame_to_seven_segment_unit.sv
// Channel   | Port     | Dir | Beat contents
// ----------+----------+-----+---------------------------------------------
// frame     | i_frame  | in  | sensor frame bytes 1..5
// segments  | o_seg    | out | four active-low seven-segment codes
//
// The pipeline is an input register stage followed by a result register.
// One frame is taken every cycle unless a stalled result fills both stages; the conversion is constant multiplies,
// one subtract/compare and a divide-by-ten by reciprocal between registers.
// Reset clears only the two stage valid bits.
// A stalled result holds in the result register; the input stage keeps
// taking beats as long as the result register is free or being drained.
module sensor_frame_to_seven_segment_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfss_frame_if.sink  i_frame,
    sfss_seg_if.source  o_seg
);

    // Stage control
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_in_free;

    // Input stage payload
    sfss_pkg::t_byte r_b1, r_b2, r_b3, r_b4, r_b5;

    // Result stage payload
    sfss_pkg::t_seg r_t_first, r_t_second, r_h_tens, r_h_units;
    sfss_pkg::t_seg n_t_first, n_t_second, n_h_tens, n_h_units;

    // Datapath
    logic [sfss_pkg::RAW_W-1:0]   w_raw_h;
    logic [sfss_pkg::RAW_W-1:0]   w_raw_t;
    logic [sfss_pkg::SCALE_W-1:0] w_scaled;
    logic [sfss_pkg::SCALE_W-1:0] w_mag;
    logic [sfss_pkg::SCALE_W-1:0] w_pos;
    logic [sfss_pkg::SCALE_W-1:0] w_mag_x10;
    logic [sfss_pkg::SCALE_W-1:0] w_pos_x10;
    logic [sfss_pkg::SCALE_W-1:0] w_h_scaled;
    logic                         w_neg;
    logic [sfss_pkg::DIGIT_W-1:0] w_d;
    logic [sfss_pkg::DIGIT_W-1:0] w_h;

    // Handshake: result register frees when empty or drained this cycle
    assign w_out_free    = !r_out_valid || o_seg.ready;
    assign w_in_free     = !r_in_valid || w_out_free;
    assign i_frame.ready = w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_free) begin
                r_in_valid <= i_frame.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_in_free && i_frame.valid) begin
            r_b1 <= i_frame.frame_byte1;
            r_b2 <= i_frame.frame_byte2;
            r_b3 <= i_frame.frame_byte3;
            r_b4 <= i_frame.frame_byte4;
            r_b5 <= i_frame.frame_byte5;
        end
    end

    // Unpack and scale
    always_comb begin
        w_raw_h    = {r_b1, r_b2, r_b3[7:4]};
        w_raw_t    = {r_b3[3:0], r_b4, r_b5};
        w_scaled   = sfss_pkg::SCALE_W'(w_raw_t) * sfss_pkg::TEMP_GAIN;
        w_neg      = w_scaled < sfss_pkg::TEMP_OFFSET_N;
        w_mag      = sfss_pkg::TEMP_OFFSET_N - w_scaled;
        w_pos      = w_scaled - sfss_pkg::TEMP_OFFSET_N;
        w_mag_x10  = w_mag * sfss_pkg::TIMES_TEN;
        w_pos_x10  = w_pos * sfss_pkg::TIMES_TEN;
        w_h_scaled = sfss_pkg::SCALE_W'(w_raw_h) * sfss_pkg::HUMID_GAIN;
    end

    // Temperature display selection
    always_comb begin
        if (w_neg) begin
            if (w_mag < sfss_pkg::FRAC_ONE) begin
                // between minus one and zero: minus-dot and tenths
                w_d       = w_mag_x10[26:20];
                n_t_first = sfss_pkg::SEG_MINUS & sfss_pkg::SEG_DOT_MASK;
            end else begin
                // minus one or below: units digit of magnitude only
                w_d       = w_mag[26:20];
                n_t_first = sfss_pkg::SEG_MINUS;
            end
        end else if (w_pos < sfss_pkg::TEN_ONE) begin
            // below ten: one decimal place
            w_d       = w_pos_x10[26:20];
            n_t_first = sfss_pkg::f_seg(sfss_pkg::f_div10(w_d)) & sfss_pkg::SEG_DOT_MASK;
        end else begin
            // ten and above, saturated
            if (w_pos[27:20] > 8'(sfss_pkg::DISPLAY_MAX)) begin
                w_d = sfss_pkg::DISPLAY_MAX;
            end else begin
                w_d = w_pos[26:20];
            end
            n_t_first = sfss_pkg::f_seg(sfss_pkg::f_div10(w_d));
        end
        n_t_second = sfss_pkg::f_seg(sfss_pkg::f_mod10(w_d));
    end

    // Humidity digits
    always_comb begin
        if (w_h_scaled[27:20] > 8'(sfss_pkg::DISPLAY_MAX)) begin
            w_h = sfss_pkg::DISPLAY_MAX;
        end else begin
            w_h = w_h_scaled[26:20];
        end
        n_h_tens  = sfss_pkg::f_seg(sfss_pkg::f_div10(w_h));
        n_h_units = sfss_pkg::f_seg(sfss_pkg::f_mod10(w_h));
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_valid) begin
            r_t_first  <= n_t_first;
            r_t_second <= n_t_second;
            r_h_tens   <= n_h_tens;
            r_h_units  <= n_h_units;
        end
    end

    assign o_seg.valid                = r_out_valid;
    assign o_seg.temp_first_segments  = r_t_first;
    assign o_seg.temp_second_segments = r_t_second;
    assign o_seg.humid_tens_segments  = r_h_tens;
    assign o_seg.humid_units_segments = r_h_units;

endmodule
